[rtl/core/cba_pkg.sv]
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and codes for the chunked bump allocator: result status codes,
// controller states and the request item that travels down the cell chain.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int WORDS_W     = 8;
  localparam int STATUS_W    = 2;
  localparam int CHUNK_NUM_W = 4;
  localparam int OFFSET_W    = 7;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_CHUNK = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   valid;
    logic                   hit;
    logic [WORDS_W-1:0]     words;
    logic [CHUNK_NUM_W-1:0] chunk;
    logic [OFFSET_W-1:0]    offset;
  } pkt_t;

endpackage

[rtl/core/chunked_bump_allocator.sv]
// ----------------------------------------------------------------------------
// chunked_bump_allocator
// Bump allocator over a row of chunk cells. A request walks the chain from
// the newest slot down to the oldest; the first open chunk with room grants
// it, otherwise the controller opens the next chunk or, when all are open, refuses it.
// ----------------------------------------------------------------------------
//   channel  | direction | ports
//   ---------+-----------+------------------------------------------------------
//   in_      | input     | in_valid, in_stall, in_request_words
//   out_     | output    | out_valid, out_stall, out_status, out_chunk_number,
//            |           | out_word_offset, out_opened_chunk
//
// A valid request enters the newest cell at its accept edge, moves one cell per
// cycle and the controller registers the decision from the oldest cell's output.
// A bad size skips the chain and gives its result in the cycle after accept. One
// item is in work at a time; in_stall stays high until the result is taken.
// Reset clears all open flags and the chunk count. out_stall holds the result
// as it is.
// ----------------------------------------------------------------------------
module chunked_bump_allocator #(
  parameter int CHUNK_WORDS = 128,
  parameter int MAX_CHUNKS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cba_pkg::WORDS_W-1:0]      in_request_words,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cba_pkg::STATUS_W-1:0]     out_status,
  output logic [cba_pkg::CHUNK_NUM_W-1:0]  out_chunk_number,
  output logic [cba_pkg::OFFSET_W-1:0]     out_word_offset,
  output logic                             out_opened_chunk
);
  import cba_pkg::*;

  localparam int FILL_W = $clog2(CHUNK_WORDS + 1);
  localparam int CW     = (FILL_W > WORDS_W) ? FILL_W : WORDS_W;
  localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
  localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [CHUNK_NUM_W-1:0] chunk_r, chunk_nxt;
  logic [OFFSET_W-1:0]    offset_r, offset_nxt;
  logic                   opened_r, opened_nxt;

  pkt_t                   chain [MAX_CHUNKS+1];
  logic                   accept;
  logic                   size_ok;
  logic                   open_en;
  logic [IDX_W-1:0]       open_idx;
  logic [CW-1:0]          words_ext;

  assign words_ext = CW'(in_request_words);
  assign size_ok   = (in_request_words != '0) && (words_ext <= CW'(CHUNK_WORDS));
  assign accept    = in_valid && !in_stall;
  assign open_idx  = cnt_r[IDX_W-1:0];

  assign chain[MAX_CHUNKS] = '{valid:  accept && size_ok,
                               hit:    1'b0,
                               words:  in_request_words,
                               chunk:  '0,
                               offset: '0};

  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
    cba_cell #(
      .CHUNK_WORDS (CHUNK_WORDS),
      .CELL_IDX    (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .pkt_in     (chain[i+1]),
      .pkt_out    (chain[i]),
      .open_en    (open_en && (open_idx == IDX_W'(i))),
      .open_words (chain[0].words)
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = size_ok ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (chain[0].valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != S_IDLE);
    out_valid  = (state_r == S_DONE);
    open_en    = 1'b0;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    chunk_nxt  = chunk_r;
    offset_nxt = offset_r;
    opened_nxt = opened_r;
    if (state_r == S_IDLE && in_valid && !size_ok) begin
      status_nxt = ST_BAD_SIZE;
      chunk_nxt  = '0;
      offset_nxt = '0;
      opened_nxt = 1'b0;
    end else if (state_r == S_SCAN && chain[0].valid) begin
      priority if (chain[0].hit) begin
        status_nxt = ST_GRANTED;
        chunk_nxt  = chain[0].chunk;
        offset_nxt = chain[0].offset;
        opened_nxt = 1'b0;
      end else if (cnt_r != CNT_W'(MAX_CHUNKS)) begin
        open_en    = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        status_nxt = ST_GRANTED;
        chunk_nxt  = CHUNK_NUM_W'(cnt_r);
        offset_nxt = '0;
        opened_nxt = 1'b1;
      end else begin
        status_nxt = ST_NO_CHUNK;
        chunk_nxt  = '0;
        offset_nxt = '0;
        opened_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    chunk_r  <= chunk_nxt;
    offset_r <= offset_nxt;
    opened_r <= opened_nxt;
  end

  assign out_status       = status_r;
  assign out_chunk_number = chunk_r;
  assign out_word_offset  = offset_r;
  assign out_opened_chunk = opened_r;

endmodule

[rtl/core/cba_cell.sv]
// ----------------------------------------------------------------------------
// cba_cell
// One chunk slot. Holds the fill level and open flag of its chunk, claims a
// passing request item when it has room, and hands the item to the next cell.
// ----------------------------------------------------------------------------
module cba_cell #(
  parameter int CHUNK_WORDS = 128,
  parameter int CELL_IDX    = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cba_pkg::pkt_t                pkt_in,
  output cba_pkg::pkt_t                pkt_out,
  input  logic                         open_en,
  input  logic [cba_pkg::WORDS_W-1:0]  open_words
);
  import cba_pkg::*;

  localparam int FILL_W = $clog2(CHUNK_WORDS + 1);
  localparam int CW     = (FILL_W > WORDS_W) ? FILL_W : WORDS_W;

  logic              open_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  pkt_t              pkt_r, pkt_nxt;
  logic [CW-1:0]     room;
  logic [CW-1:0]     words_ext;
  logic [CW-1:0]     fill_ext;
  logic              fits;

  assign fill_ext  = CW'(fill_r);
  assign room      = CW'(CHUNK_WORDS) - fill_ext;
  assign words_ext = CW'(pkt_in.words);
  assign fits      = open_r && (words_ext <= room);

  always_comb begin
    pkt_nxt  = pkt_in;
    fill_nxt = fill_r;
    if (pkt_in.valid && !pkt_in.hit && fits) begin
      pkt_nxt.hit    = 1'b1;
      pkt_nxt.chunk  = CHUNK_NUM_W'(CELL_IDX);
      pkt_nxt.offset = fill_ext[OFFSET_W-1:0];
      fill_nxt       = fill_r + FILL_W'(pkt_in.words);
    end
    if (open_en) begin
      fill_nxt = FILL_W'(open_words);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      pkt_r  <= '0;
    end else begin
      if (open_en) begin
        open_r <= 1'b1;
      end
      pkt_r <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
  end

  assign pkt_out = pkt_r;

endmodule

[rtl/core/cba_checker.sv]
// ----------------------------------------------------------------------------
// cba_checker
// Port-level checks for the chunked bump allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cba_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [cba_pkg::STATUS_W-1:0]     out_status,
  input logic [cba_pkg::CHUNK_NUM_W-1:0]  out_chunk_number,
  input logic [cba_pkg::OFFSET_W-1:0]     out_word_offset,
  input logic                             out_opened_chunk
);
  import cba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_chunk_number) && $stable(out_word_offset) && $stable(out_opened_chunk))
    else $error("result item changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in work");

  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_GRANTED |->
      out_chunk_number == '0 && out_word_offset == '0 && !out_opened_chunk)
    else $error("refused item carries grant fields");

  a_open_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_opened_chunk |-> out_status == ST_GRANTED && out_word_offset == '0)
    else $error("new chunk granted at nonzero offset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_GRANTED || out_status == ST_BAD_SIZE ||
      out_status == ST_NO_CHUNK)
    else $error("undefined status code");

endmodule

bind chunked_bump_allocator cba_checker u_cba_checker (.*);
